// File: rtl/twhcp_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes, register indexes and the sine helper for the
// two-wave harmonic color pattern block. No dependencies.
package twhcp_pkg;

  // Default sizes
  localparam int unsigned HARMONIC_TERMS_DEF  = 4;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned TERM_W              = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_COLOR_LEVELS    = 3'd0;
  localparam logic [2:0] REG_RIGHT_WEIGHT    = 3'd1;
  localparam logic [2:0] REG_INDEX_STEPS     = 3'd2;
  localparam logic [2:0] REG_TIME_RATES      = 3'd3;
  localparam logic [2:0] REG_RIGHT_HARMONICS = 3'd4;
  localparam logic [2:0] REG_LEFT_HARMONICS  = 3'd5;
  localparam logic [2:0] REG_LIGHT_COUNT     = 3'd6;

  // Register reset values
  localparam logic [47:0] COLOR_LEVELS_RST = 48'hFFFF_FF00_0000;
  localparam logic [16:0] RIGHT_WEIGHT_RST = 17'd32768;
  localparam logic [63:0] HARMONICS_RST    = 64'd16384;
  localparam logic [16:0] LIGHT_COUNT_RST  = 17'd256;
  localparam logic [16:0] WEIGHT_ONE       = 17'd65536;

  // Datapath operation codes
  localparam logic [3:0] A_NONE     = 4'd0;
  localparam logic [3:0] A_LOAD     = 4'd1;
  localparam logic [3:0] A_CLR      = 4'd2;
  localparam logic [3:0] A_MUL_ADV  = 4'd3;
  localparam logic [3:0] A_ACC_ADV  = 4'd4;
  localparam logic [3:0] A_MUL_PH   = 4'd5;
  localparam logic [3:0] A_SET_PH   = 4'd6;
  localparam logic [3:0] A_LOOK     = 4'd7;
  localparam logic [3:0] A_MUL_TERM = 4'd8;
  localparam logic [3:0] A_ACC_TERM = 4'd9;
  localparam logic [3:0] A_MUL_BL   = 4'd10;
  localparam logic [3:0] A_ACC_BL   = 4'd11;
  localparam logic [3:0] A_MUL_CH   = 4'd12;
  localparam logic [3:0] A_SET_CH   = 4'd13;
  localparam logic [3:0] A_OUT      = 4'd14;

  // Wave and channel selects
  localparam logic       WAVE_RIGHT = 1'b0;
  localparam logic       WAVE_LEFT  = 1'b1;
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_GREEN   = 2'd1;
  localparam logic [1:0] CH_BLUE    = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic [3:0]        act;
    logic              wave;
    logic [TERM_W-1:0] term;
    logic [1:0]        chan;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic in_range;
  } dp_stat_t;

  // Quarter-wave sine magnitude in Q14 for offset o of a table with tb bits
  function automatic logic [14:0] sine_quarter(input int unsigned o, input int unsigned tb);
    logic signed [63:0] u;
    logic signed [63:0] u2;
    logic signed [63:0] p;
    logic signed [63:0] r;
    logic signed [63:0] v;
    u  = 64'(o) << (30 - (tb - 2));
    u2 = (u * u) >>> 30;
    p  = 64'sd172272;
    p  = -64'sd5026995 + ((p * u2) >>> 30);
    p  = 64'sd85569306 + ((p * u2) >>> 30);
    p  = -64'sd693598668 + ((p * u2) >>> 30);
    p  = 64'sd1686629713 + ((p * u2) >>> 30);
    r  = (p * u) >>> 30;
    v  = (r + 64'sd32768) >>> 16;
    if (v < 0) v = 0;
    if (v > 16384) v = 16384;
    return v[14:0];
  endfunction

endpackage

// File: rtl/twhcp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the color pattern block: handshakes and datapath step order.
// Depends on twhcp_pkg.
module twhcp_ctrl import twhcp_pkg::*; #(
  parameter int unsigned HARMONIC_TERMS = HARMONIC_TERMS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_ADV   = 3'd2;
  localparam logic [2:0] ST_PH    = 3'd3;
  localparam logic [2:0] ST_TERM  = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_CHAN  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;
  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(HARMONIC_TERMS - 1);

  logic [2:0]        state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic              wave_q, wave_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic [1:0]        chan_q, chan_d;
  logic              out_valid_q, out_valid_d;

  // Next state and step commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    wave_d  = wave_q;
    term_d  = term_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.act = A_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = A_LOAD;
          state_d   = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd_o.act = A_CLR;
        step_d = '0;
        wave_d = WAVE_RIGHT;
        term_d = '0;
        chan_d = CH_RED;
        if (!stat_i.is_query) state_d = ST_ADV;
        else if (!stat_i.in_range) state_d = ST_DONE;
        else state_d = ST_PH;
      end
      ST_ADV, ST_PH, ST_BLEND: begin
        // multiply then use, right wave then left
        cmd_o.wave = step_q[1];
        step_d = step_q + 2'd1;
        if (state_q == ST_ADV) cmd_o.act = step_q[0] ? A_ACC_ADV : A_MUL_ADV;
        else if (state_q == ST_PH) cmd_o.act = step_q[0] ? A_SET_PH : A_MUL_PH;
        else cmd_o.act = step_q[0] ? A_ACC_BL : A_MUL_BL;
        if (step_q == 2'd3) begin
          if (state_q == ST_ADV) state_d = ST_IDLE;
          else if (state_q == ST_PH) state_d = ST_TERM;
          else state_d = ST_CHAN;
        end
      end
      ST_TERM: begin
        cmd_o.wave = wave_q;
        cmd_o.term = term_q;
        if (step_q == 2'd0) cmd_o.act = A_LOOK;
        else if (step_q == 2'd1) cmd_o.act = A_MUL_TERM;
        else cmd_o.act = A_ACC_TERM;
        if (step_q == 2'd2) begin
          step_d = '0;
          if (term_q == TERM_LAST) begin
            term_d = '0;
            if (wave_q == WAVE_LEFT) state_d = ST_BLEND;
            else wave_d = WAVE_LEFT;
          end else begin
            term_d = term_q + TERM_W'(1);
          end
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_CHAN: begin
        cmd_o.chan = chan_q;
        cmd_o.act  = step_q[0] ? A_SET_CH : A_MUL_CH;
        if (step_q[0]) begin
          step_d = '0;
          if (chan_q == CH_BLUE) state_d = ST_DONE;
          else chan_d = chan_q + 2'd1;
        end else begin
          step_d = 2'd1;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.act = A_OUT;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.act == A_OUT) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      wave_q      <= WAVE_RIGHT;
      term_q      <= '0;
      chan_q      <= CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      wave_q      <= wave_d;
      term_q      <= term_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/twhcp_dp.sv
`timescale 1ns / 1ps
// Datapath of the color pattern block: config registers, phases, sine table,
// one shared multiplier, accumulators and result registers. Depends on twhcp_pkg.
module twhcp_dp import twhcp_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        command_i,
  input  logic [15:0] time_step_i,
  input  logic [15:0] light_index_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        in_range_o
);

  localparam int unsigned B  = SINE_TABLE_BITS;
  localparam int unsigned QN = 1 << (B - 2);

  typedef logic [14:0] qtab_t [QN+1];

  function automatic qtab_t build_tab();
    qtab_t t;
    for (int unsigned o = 0; o <= QN; o++) t[o] = sine_quarter(o, B);
    return t;
  endfunction

  localparam qtab_t QTAB = build_tab();

  // Config registers
  logic [47:0] color_q;
  logic [16:0] rweight_q;
  logic [63:0] isteps_q;
  logic [47:0] trates_q;
  logic [63:0] rharm_q;
  logic [63:0] lharm_q;
  logic [16:0] lcount_q;

  // Work registers
  logic                cmd_q;
  logic [15:0]         dt_q;
  logic [15:0]         idx_q;
  logic [31:0]         ph_r_q, ph_l_q;
  logic [31:0]         qph_r_q, qph_l_q;
  logic signed [15:0]  ent_q;
  logic signed [69:0]  prod_q;
  logic signed [33:0]  sum_r_q, sum_l_q;
  logic signed [51:0]  y_q;
  logic [7:0]          ch_q [3];
  logic [7:0]          red_q, green_q, blue_q;
  logic                inr_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q   <= COLOR_LEVELS_RST;
      rweight_q <= RIGHT_WEIGHT_RST;
      isteps_q  <= '0;
      trates_q  <= '0;
      rharm_q   <= HARMONICS_RST;
      lharm_q   <= HARMONICS_RST;
      lcount_q  <= LIGHT_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLOR_LEVELS:    color_q   <= cfg_data_i[47:0];
        REG_RIGHT_WEIGHT:    rweight_q <= cfg_data_i[16:0];
        REG_INDEX_STEPS:     isteps_q  <= cfg_data_i;
        REG_TIME_RATES:      trates_q  <= cfg_data_i[47:0];
        REG_RIGHT_HARMONICS: rharm_q   <= cfg_data_i;
        REG_LEFT_HARMONICS:  lharm_q   <= cfg_data_i;
        REG_LIGHT_COUNT:     lcount_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Status
  assign stat_o.is_query = cmd_q;
  assign stat_o.in_range = ({1'b0, idx_q} < lcount_q);

  // Operand selects
  logic [31:0]        qph_w;
  logic [31:0]        hp;
  logic [B-1:0]       tab_i;
  logic [B-2:0]       tab_a;
  logic [15:0]        coef;
  logic [16:0]        wr;
  logic [7:0]         hi, lo;
  logic signed [51:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [69:0] ch_val;
  logic signed [24:0] ch_c;

  assign qph_w = (cmd_i.wave == WAVE_LEFT) ? qph_l_q : qph_r_q;
  assign coef  = (cmd_i.wave == WAVE_LEFT) ? lharm_q[16*cmd_i.term +: 16]
                                           : rharm_q[16*cmd_i.term +: 16];
  assign wr    = (rweight_q > WEIGHT_ONE) ? WEIGHT_ONE : rweight_q;

  // Harmonic phase: k times phase, k at most four
  always_comb begin
    unique case (cmd_i.term)
      2'd0:    hp = qph_w;
      2'd1:    hp = qph_w << 1;
      2'd2:    hp = qph_w + (qph_w << 1);
      default: hp = qph_w << 2;
    endcase
  end

  // Quadrant fold into the quarter table
  assign tab_i = hp[31 -: B];
  assign tab_a = tab_i[B-2] ? ((B-1)'(QN) - {1'b0, tab_i[B-3:0]})
                            : {1'b0, tab_i[B-3:0]};

  // Channel color bytes
  always_comb begin
    unique case (cmd_i.chan)
      CH_RED:   begin hi = color_q[47:40]; lo = color_q[23:16]; end
      CH_GREEN: begin hi = color_q[39:32]; lo = color_q[15:8];  end
      default:  begin hi = color_q[31:24]; lo = color_q[7:0];   end
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.act)
      A_MUL_ADV: begin
        mul_a = {28'd0, (cmd_i.wave == WAVE_LEFT) ? trates_q[23:0] : trates_q[47:24]};
        mul_b = {2'd0, dt_q};
      end
      A_MUL_PH: begin
        mul_a = {20'd0, (cmd_i.wave == WAVE_LEFT) ? isteps_q[31:0] : isteps_q[63:32]};
        mul_b = {2'd0, idx_q};
      end
      A_MUL_TERM: begin
        mul_a = 52'(signed'(coef));
        mul_b = 18'(ent_q);
      end
      A_MUL_BL: begin
        mul_a = (cmd_i.wave == WAVE_LEFT) ? 52'(sum_l_q) : 52'(sum_r_q);
        mul_b = (cmd_i.wave == WAVE_LEFT) ? {1'b0, 17'(WEIGHT_ONE - wr)} : {1'b0, wr};
      end
      A_MUL_CH: begin
        mul_a = y_q;
        mul_b = 18'(signed'({1'b0, hi}) - signed'({1'b0, lo}));
      end
      default: ;
    endcase
  end

  // Channel mapping: floor shift and clamp
  assign ch_val = (70'(9'({1'b0, hi} + {1'b0, lo})) <<< 44) + prod_q;
  assign ch_c   = 25'(ch_val >>> 45);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Phase accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_r_q <= '0;
      ph_l_q <= '0;
    end else if (cmd_i.act == A_ACC_ADV) begin
      if (cmd_i.wave == WAVE_LEFT) ph_l_q <= ph_l_q + prod_q[31:0];
      else ph_r_q <= ph_r_q + prod_q[31:0];
    end
  end

  // Item, sums and channel registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.act)
      A_LOAD: begin
        cmd_q <= command_i;
        dt_q  <= time_step_i;
        idx_q <= light_index_i;
      end
      A_CLR: begin
        sum_r_q <= '0;
        sum_l_q <= '0;
      end
      A_SET_PH: begin
        if (cmd_i.wave == WAVE_LEFT) qph_l_q <= prod_q[31:0] + ph_l_q;
        else qph_r_q <= prod_q[31:0] - ph_r_q;
      end
      A_LOOK: begin
        ent_q <= tab_i[B-1] ? -signed'({1'b0, QTAB[tab_a]}) : signed'({1'b0, QTAB[tab_a]});
      end
      A_ACC_TERM: begin
        if (cmd_i.wave == WAVE_LEFT) sum_l_q <= sum_l_q + prod_q[33:0];
        else sum_r_q <= sum_r_q + prod_q[33:0];
      end
      A_ACC_BL: begin
        if (cmd_i.wave == WAVE_LEFT) y_q <= y_q + prod_q[51:0];
        else y_q <= prod_q[51:0];
      end
      A_SET_CH: begin
        if (ch_c < 0) ch_q[cmd_i.chan] <= 8'd0;
        else if (ch_c > 25'sd255) ch_q[cmd_i.chan] <= 8'd255;
        else ch_q[cmd_i.chan] <= ch_c[7:0];
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == A_OUT) begin
      inr_q   <= stat_o.in_range;
      red_q   <= stat_o.in_range ? ch_q[CH_RED]   : 8'd0;
      green_q <= stat_o.in_range ? ch_q[CH_GREEN] : 8'd0;
      blue_q  <= stat_o.in_range ? ch_q[CH_BLUE]  : 8'd0;
    end
  end

  assign red_o      = red_q;
  assign green_o    = green_q;
  assign blue_o     = blue_q;
  assign in_range_o = inr_q;

endmodule

// File: rtl/two_wave_harmonic_color_pattern.sv
`timescale 1ns / 1ps
// Top level of the two-wave harmonic LED color pattern generator.
// Depends on twhcp_pkg, twhcp_ctrl and twhcp_dp.

// An advance item (command 0) moves both wave phases forward and gives no
// result. A query item (command 1) gives one RGB result; an in-range query
// computes every product in turn on the single shared multiplier, and an
// out-of-range query skips the phase, term, blend and channel steps. A query
// also holds in its done state while the previous result is still waiting to
// be taken. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. Configuration writes are
// always accepted and must only be made while idle.
module two_wave_harmonic_color_pattern import twhcp_pkg::*; #(
  parameter int unsigned HARMONIC_TERMS  = HARMONIC_TERMS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] time_step_i,
  input  logic [15:0] light_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        in_range_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  twhcp_ctrl #(
    .HARMONIC_TERMS(HARMONIC_TERMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  twhcp_dp #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .time_step_i  (time_step_i),
    .light_index_i(light_index_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .in_range_o   (in_range_o)
  );

endmodule
